[src/tea_pkg.sv]
// Shared types, constants and the TEA mixing function for the TEA cipher block.
package tea_pkg;

  localparam logic [31:0] Delta = 32'h9E37_79B9;
  localparam logic [7:0]  RoundsReset = 8'd32;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_ROUNDS = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic        func;
    logic [31:0] block_y;
    logic [31:0] block_z;
  } in_t;

  typedef struct packed {
    logic [31:0] out_y;
    logic [31:0] out_z;
  } out_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  function automatic logic [31:0] mix(input logic [31:0] v, input logic [31:0] sum,
                                      input logic [31:0] kl, input logic [31:0] kr);
    mix = ((v << 4) + kl) ^ (v + sum) ^ ((v >> 5) + kr);
  endfunction

endpackage

[src/tea_half_round.sv]
// One TEA half-round: the shared mix unit and the add or subtract into one half.
module tea_half_round (
  input  logic                func_i,
  input  logic                phase_i,
  input  logic [31:0]         y_i,
  input  logic [31:0]         z_i,
  input  logic [31:0]         sum_i,
  input  tea_pkg::key_t       key_i,
  output logic [31:0]         y_o,
  output logic [31:0]         z_o
);

  logic        src_is_z;
  logic [31:0] v;
  logic [31:0] kl;
  logic [31:0] kr;
  logic [31:0] target;
  logic [31:0] m;
  logic [31:0] upd;

  // The mix reads z and updates y when the phase matches the direction;
  // otherwise it reads y and updates z.
  assign src_is_z = (phase_i == func_i);
  assign v        = src_is_z ? z_i : y_i;
  assign kl       = src_is_z ? key_i.k0 : key_i.k2;
  assign kr       = src_is_z ? key_i.k1 : key_i.k3;
  assign target   = src_is_z ? y_i : z_i;
  assign m        = tea_pkg::mix(v, sum_i, kl, kr);
  assign upd      = (func_i == tea_pkg::FUNC_DEC) ? (target - m) : (target + m);

  assign y_o = src_is_z ? upd : y_i;
  assign z_o = src_is_z ? z_i : upd;

endmodule

[src/tea_block_cipher_unit.sv]
// TEA cipher block: one 64-bit block per beat, one half-round per cycle.
// A new input beat is taken only while the core is idle; input stalls for the
// whole run, since the single mix unit does one half-round each cycle. A run
// that finishes while a result is still waiting holds in the core, and so
// keeps input stalled; a waiting result alone does not block input.
// Reset clears the key words to zero, rounds to 32 and empties the core.
module tea_block_cipher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tea_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tea_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tea_pkg::out_t                 out_data_o
);

  tea_pkg::key_t   key_q;
  logic [7:0]      rounds_q;
  tea_pkg::state_e state_q, state_d;
  logic            func_q;
  logic            phase_q, phase_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [31:0]     y_q, y_d;
  logic [31:0]     z_q, z_d;
  logic [31:0]     sum_q, sum_d;
  logic            out_valid_q, out_valid_d;
  tea_pkg::out_t   out_q, out_d;
  logic [31:0]     y_nx;
  logic [31:0]     z_nx;
  logic            in_fire;
  logic            out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= tea_pkg::RoundsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tea_pkg::CFG_KEY0:   key_q.k0 <= cfg_wdata_i;
        tea_pkg::CFG_KEY1:   key_q.k1 <= cfg_wdata_i;
        tea_pkg::CFG_KEY2:   key_q.k2 <= cfg_wdata_i;
        tea_pkg::CFG_KEY3:   key_q.k3 <= cfg_wdata_i;
        tea_pkg::CFG_ROUNDS: rounds_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  tea_half_round u_half_round (
    .func_i  (func_q),
    .phase_i (phase_q),
    .y_i     (y_q),
    .z_i     (z_q),
    .sum_i   (sum_q),
    .key_i   (key_q),
    .y_o     (y_nx),
    .z_o     (z_nx)
  );

  assign in_stall_o = (state_q != tea_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    y_d         = y_q;
    z_d         = z_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      tea_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = tea_pkg::ST_RUN;
          phase_d = 1'b0;
          cnt_d   = rounds_q;
          y_d     = in_data_i.block_y;
          z_d     = in_data_i.block_z;
          // Decryption starts from the sum that encryption ends with.
          sum_d   = (in_data_i.func == tea_pkg::FUNC_DEC) ?
                    32'(tea_pkg::Delta * {24'd0, rounds_q}) : tea_pkg::Delta;
        end
      end
      tea_pkg::ST_RUN: begin
        if (cnt_q == 8'd0) begin
          if (out_free) begin
            out_d.out_y = y_q;
            out_d.out_z = z_q;
            out_valid_d = 1'b1;
            state_d     = tea_pkg::ST_IDLE;
          end
        end else begin
          y_d     = y_nx;
          z_d     = z_nx;
          phase_d = !phase_q;
          if (phase_q) begin
            cnt_d = cnt_q - 8'd1;
            sum_d = (func_q == tea_pkg::FUNC_DEC) ? (sum_q - tea_pkg::Delta) :
                                                    (sum_q + tea_pkg::Delta);
          end
        end
      end
      default: state_d = tea_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tea_pkg::ST_IDLE;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    z_q   <= z_d;
    sum_q <= sum_d;
    out_q <= out_d;
    if (in_fire) begin
      func_q <= in_data_i.func;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // An accepted beat starts a run with the configured round count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == tea_pkg::ST_RUN) && (cnt_q == $past(rounds_q)))
    else $error("run did not start with the configured round count");

  // A new result only appears as a run finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == tea_pkg::ST_RUN) &&
                           ($past(cnt_q) == 8'd0) && (state_q == tea_pkg::ST_IDLE))
    else $error("result appeared outside the end of a run");

  // The second half of a round never runs with no rounds left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tea_pkg::ST_RUN) && phase_q) |-> (cnt_q != 8'd0))
    else $error("half-round phase out of step with the round count");

  // A finished run never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("waiting result was overwritten");
`endif

endmodule
